>>> rtl/core/brb_pkg.sv
// shared types, codes and defaults for the byte ring buffer
`default_nettype none

package brb_pkg;

    // default number of storage slots
    localparam int unsigned SIZE_DEFAULT = 64;

    // field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TDATA_W  = 16;

    // operation codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE    = 2'd0,
        MODE_READ     = 2'd1,
        MODE_READ_IDX = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RSVD  = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture a new transaction and start the slot read
        logic commit;  // update pointers and storage, load the result register
    } brb_cmd_t;

endpackage : brb_pkg

`default_nettype wire

>>> rtl/core/brb_ram.sv
// generic single-write, single-read RAM with registered read data
`default_nettype none

module brb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire  logic                     aclk,
    input  wire  logic                     we,
    input  wire  logic [$clog2(DEPTH)-1:0] waddr,
    input  wire  logic [WIDTH-1:0]         wdata,
    input  wire  logic                     re,
    input  wire  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : brb_ram

`default_nettype wire

>>> rtl/core/brb_ctrl.sv
// controller state machine sequencing one transaction at a time
`default_nettype none

module brb_ctrl (
    input  wire  logic              aclk,
    input  wire  logic              aresetn,
    input  wire  logic              s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire  logic              m_tready,
    output brb_pkg::brb_cmd_t       cmd
);

    import brb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // output register can take a new result this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    // no transaction is taken while reset is held
    assign s_tready   = aresetn && (state_reg == ST_IDLE);
    assign cmd.load   = s_tready && s_tvalid;
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid   = m_tvalid_reg;

    // next state and output valid
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a loaded transaction always moves on to execution
    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("load not followed by execute state");

    // load and commit never coincide
    a_load_commit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.commit))
        else $error("load and commit in the same cycle");

    // a commit always leaves a result on the output
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("commit without output valid");

endmodule : brb_ctrl

`default_nettype wire

>>> rtl/core/brb_dp.sv
// datapath: pointers, slot storage with valid bits and the result register
`default_nettype none

module brb_dp #(
    parameter int unsigned SIZE = brb_pkg::SIZE_DEFAULT
) (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    input  wire  brb_pkg::brb_cmd_t             cmd,
    input  wire  logic                          overwrite,
    input  wire  logic [brb_pkg::MODE_W-1:0]    in_mode,
    input  wire  logic [brb_pkg::BYTE_W-1:0]    in_data,
    input  wire  logic [brb_pkg::IDX_W-1:0]     in_idx,
    output logic [brb_pkg::BYTE_W-1:0]          out_data,
    output logic [brb_pkg::STATUS_W-1:0]        out_status,
    output logic                                out_full,
    output logic                                out_empty
);

    import brb_pkg::*;

    localparam int unsigned AW = $clog2(SIZE);
    localparam logic [AW-1:0] LAST = AW'(SIZE - 1);

    // transaction registers
    mode_t             mode_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              hit_reg;

    // buffer state
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [SIZE-1:0]   valid_reg, valid_next;

    // result register
    logic [BYTE_W-1:0] dout_reg, dout_next;
    status_t           status_reg, status_next;
    logic              full_reg, empty_reg;

    // read side
    logic [8:0]        idx_ext;
    logic              idx_in_range;
    logic [AW-1:0]     raddr;
    logic              raddr_ok;
    logic [BYTE_W-1:0] ram_q;
    logic [BYTE_W-1:0] rd_byte;
    logic              ram_we;
    logic              is_full, is_empty;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        adv = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // read address: head for a pop, the raw slot otherwise
    assign idx_ext      = {3'b000, in_idx};
    assign idx_in_range = (idx_ext < 9'(SIZE));
    assign raddr        = (mode_t'(in_mode) == MODE_READ) ? head_reg : idx_ext[AW-1:0];
    assign raddr_ok     = (mode_t'(in_mode) == MODE_READ) || idx_in_range;

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SIZE)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (data_reg),
        .re    (cmd.load),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode_t'(in_mode);
            data_reg <= in_data;
            hit_reg  <= raddr_ok && valid_reg[raddr];
        end
    end

    // a never-written or cleared slot reads as zero
    assign rd_byte  = hit_reg ? ram_q : '0;
    assign is_full  = (adv(tail_reg) == head_reg);
    assign is_empty = (tail_reg == head_reg);

    // execute the operation
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        valid_next  = valid_reg;
        dout_next   = '0;
        status_next = STAT_OK;
        ram_we      = 1'b0;
        unique case (mode_reg)
            MODE_WRITE: begin
                if (is_full && !overwrite) begin
                    status_next = STAT_FULL;
                end else begin
                    if (is_full) begin
                        head_next = adv(head_reg);
                    end
                    ram_we              = cmd.commit;
                    valid_next[tail_reg] = 1'b1;
                    tail_next           = adv(tail_reg);
                end
            end
            MODE_READ: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    dout_next = rd_byte;
                    head_next = adv(head_reg);
                end
            end
            MODE_READ_IDX: begin
                dout_next = rd_byte;
            end
            MODE_CLEAR: begin
                head_next  = '0;
                tail_next  = '0;
                valid_next = '0;
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    // buffer state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            valid_reg <= '0;
        end else if (cmd.commit) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            valid_reg <= valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            dout_reg   <= dout_next;
            status_reg <= status_next;
            full_reg   <= (adv(tail_next) == head_next);
            empty_reg  <= (tail_next == head_next);
        end
    end

    assign out_data   = dout_reg;
    assign out_status = status_reg;
    assign out_full   = full_reg;
    assign out_empty  = empty_reg;

    // pointers stay inside the store
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= LAST) && (tail_reg <= LAST))
        else $error("pointer beyond last slot");

    // a result never reports full and empty together
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.commit) |-> !(full_reg && empty_reg))
        else $error("full and empty both set");

    // a rejected write leaves the buffer full
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.commit) && (status_reg == STAT_FULL)) |-> full_reg)
        else $error("write rejected while not full");

endmodule : brb_dp

`default_nettype wire

>>> rtl/core/byte_ring_buffer.sv
// byte ring buffer top level: stream channels, register port, control and datapath
//
// Usage: each input transaction on s_tdata carries mode, data_in and slot_index
// and produces exactly one result transaction on m_tdata with data_out, status
// and the full and empty flags as they stand after the operation. Modes are
// append a byte, pop the oldest byte, read a raw slot, and clear.
// The store has SIZE slots and holds at most SIZE-1 bytes.
// Sequence: an accepted transaction starts the registered read of its slot in
// the RAM; the execute state then commits the pointer and storage update and
// loads the result register once the output register is free, raising m_tvalid.
// One transaction is in flight at a time: no new one is taken until it commits.
// Register overwrite_when_full at APB address 0 selects drop-oldest on a write
// to a full buffer; otherwise such a write is rejected with status 1.
// Reset (aresetn low, synchronous) empties the buffer, marks every slot as zero
// through per-slot valid bits and clears the register; no clearing pass is needed.
// A clear transaction does the same for the store, also with no clearing pass.
// When the receiver stalls, the result stays in the output register and the
// next input transaction is accepted but held before execution until it frees.
`default_nettype none

module byte_ring_buffer #(
    parameter int unsigned SIZE = brb_pkg::SIZE_DEFAULT
) (
    input  wire  logic                         aclk,
    input  wire  logic                         aresetn,
    // input channel
    input  wire  logic                         s_tvalid,
    output logic                               s_tready,
    input  wire  logic [brb_pkg::TDATA_W-1:0]  s_tdata,  // mode[1:0], data_in[9:2], slot_index[15:10]
    // result channel
    output logic                               m_tvalid,
    input  wire  logic                         m_tready,
    output logic [brb_pkg::TDATA_W-1:0]        m_tdata,  // data_out[7:0], status[9:8], full[10], empty[11], zero[15:12]
    // register port
    input  wire  logic                         psel,
    input  wire  logic                         penable,
    input  wire  logic                         pwrite,
    input  wire  logic [2:0]                   paddr,
    input  wire  logic [31:0]                  pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import brb_pkg::*;

    brb_cmd_t              cmd;
    logic                  ow_reg;
    logic                  reg_sel;
    logic [BYTE_W-1:0]     out_data;
    logic [STATUS_W-1:0]   out_status;
    logic                  out_full;
    logic                  out_empty;

    // register decode on the word address
    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'b0, ow_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ow_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            ow_reg <= pwdata[0];
        end
    end

    brb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    brb_dp #(
        .SIZE (SIZE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .overwrite  (ow_reg),
        .in_mode    (s_tdata[1:0]),
        .in_data    (s_tdata[9:2]),
        .in_idx     (s_tdata[15:10]),
        .out_data   (out_data),
        .out_status (out_status),
        .out_full   (out_full),
        .out_empty  (out_empty)
    );

    // pack the result
    assign m_tdata = {4'b0000, out_empty, out_full, out_status, out_data};

endmodule : byte_ring_buffer

`default_nettype wire
